// File: rtl/ecbm_pkg.sv
// Shared widths, codes, types and the reload function of the event cart bank mapper.
`timescale 1ns / 1ps

package ecbm_pkg;

   localparam int REG_COUNT  = 4;
   localparam int IDX_W      = 2;
   localparam int VAL_W      = 5;
   localparam int BANK_W     = 4;
   localparam int COUNT_W    = 30;
   localparam int SETTING_W  = 4;

   // Base unit of the timer reload; reload_value scales it by the setting plus SETTING_OFFSET, less one.
   localparam int BASE_PERIOD    = 33554432;
   localparam int SETTING_OFFSET = 16;
   localparam int RELOAD_W       = COUNT_W + 6;

   localparam logic [SETTING_W-1:0] SETTING_RESET = SETTING_W'(4);
   localparam logic [VAL_W-1:0]     REG0_RESET    = VAL_W'(5'h0C);

   // Item kinds.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_MODE    = 2'd0;
   localparam logic [IDX_W-1:0] REG_CONTROL = 2'd1;
   localparam logic [IDX_W-1:0] REG_UNUSED  = 2'd2;
   localparam logic [IDX_W-1:0] REG_INNER   = 2'd3;

   // Bit positions in the control register.
   localparam int HOLD_BIT  = 4;
   localparam int INNER_BIT = 3;

   // Inner program modes, register 0 bits 3..2.
   localparam logic [1:0] INNER_FIXED_FIRST = 2'b10;
   localparam logic [1:0] INNER_FIXED_LAST  = 2'b11;

   localparam logic [BANK_W-1:0] BANK_INNER_BASE = BANK_W'(8);
   localparam logic [BANK_W-1:0] BANK_LAST       = BANK_W'(15);

   // Largest count the timer can ever hold.
   localparam logic [COUNT_W-1:0] COUNT_MAX =
      COUNT_W'(BASE_PERIOD * (SETTING_OFFSET + 15) - 1);

   typedef struct packed {
      logic step;   // an item leaves the input register this cycle
      logic tick;   // that item is one CPU cycle
      logic arm;    // that item writes register 1 or 3
      logic hold;   // hold bit after the write
   } timer_ctrl_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               irq;
   } timer_state_type;

   function automatic logic [COUNT_W-1:0] reload_value(input logic [SETTING_W-1:0] setting);
      logic [RELOAD_W-1:0] prod;
      prod = RELOAD_W'(BASE_PERIOD) * (RELOAD_W'(setting) + RELOAD_W'(SETTING_OFFSET))
             - RELOAD_W'(1);
      return prod[COUNT_W-1:0];
   endfunction

endpackage

// File: rtl/ecbm_req_if.sv
// Input item channel: a register write or one CPU-cycle tick.
`timescale 1ns / 1ps

interface ecbm_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [1:0] reg_index;
   logic [4:0] reg_value;

   modport source (output valid, output mode, output reg_index, output reg_value,
                   input ready);
   modport sink (input valid, input mode, input reg_index, input reg_value,
                 output ready);
endinterface

// File: rtl/ecbm_rsp_if.sv
// Result item channel: program banks, interrupt line and remaining count.
`timescale 1ns / 1ps

interface ecbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  prg_bank_first;
   logic [3:0]  prg_bank_second;
   logic        irq_line;
   logic [29:0] count_left;

   modport source (output valid, output prg_bank_first, output prg_bank_second,
                   output irq_line, output count_left, input ready);
   modport sink (input valid, input prg_bank_first, input prg_bank_second,
                 input irq_line, input count_left, output ready);
endinterface

// File: rtl/ecbm_csr_if.sv
// Configuration write channel carrying the timer setting.
`timescale 1ns / 1ps

interface ecbm_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/event_cart_bank_map_and_timer_unit.sv
// Top level of the event cart bank mapper with countdown timer.
`timescale 1ns / 1ps

// Path: an accepted item waits in the input register, then its result is loaded into the result
// register. Throughput: one item per cycle while results are taken, else the block stalls;
// the state update is a single pass between the two registers.
// The block keeps taking items while a result waits, and stalls only when both registers are full.
// Reset is synchronous and active high: registers 0x0C/0/0/0, count zero, interrupt clear,
// timer setting 4. The configuration port is always ready.
module event_cart_bank_map_and_timer_unit (
   input  logic       clock,
   input  logic       reset,
   ecbm_req_if.sink   req_ch,
   ecbm_rsp_if.source rsp_ch,
   ecbm_csr_if.sink   csr_ch
);
   import ecbm_pkg::*;

   // Timer setting, written through the configuration channel.
   logic [SETTING_W-1:0] setting_ff, setting_in;

   // Input register.
   logic             in_valid_ff, in_valid_in;
   logic             in_mode_ff;
   logic [IDX_W-1:0] in_index_ff;
   logic [VAL_W-1:0] in_value_ff;

   // Mapper registers.
   logic [VAL_W-1:0] regs_ff [REG_COUNT];
   logic [VAL_W-1:0] regs_in [REG_COUNT];

   // Result register.
   logic               out_valid_ff, out_valid_in;
   logic [BANK_W-1:0]  out_first_ff, out_second_ff;
   logic               out_irq_ff;
   logic [COUNT_W-1:0] out_count_ff;

   logic               advance;
   logic               is_write;
   logic               hold_bit;
   timer_ctrl_type     timer_ctrl;
   timer_state_type    timer_next;
   logic [BANK_W-1:0]  bank_first, bank_second;

   // The item in the input register moves on whenever the result register is free or drains.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign in_valid_in  = (req_ch.valid && req_ch.ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   assign setting_in   = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : setting_ff;

   assign is_write = (in_mode_ff == MODE_WRITE);

   // The hold bit is taken from register 1 after this item's write.
   assign hold_bit = (in_index_ff == REG_CONTROL) ? in_value_ff[HOLD_BIT]
                                                  : regs_ff[REG_CONTROL][HOLD_BIT];

   always_comb begin
      for (int i = 0; i < REG_COUNT; i++) begin
         regs_in[i] = regs_ff[i];
      end
      if (advance && is_write) begin
         regs_in[in_index_ff] = in_value_ff;
      end
   end

   assign timer_ctrl.step = advance;
   assign timer_ctrl.tick = (in_mode_ff == MODE_TICK);
   assign timer_ctrl.arm  = is_write &&
                            (in_index_ff == REG_CONTROL || in_index_ff == REG_INNER);
   assign timer_ctrl.hold = hold_bit;

   ecbm_timer u_timer (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (timer_ctrl),
      .setting    (setting_ff),
      .next_state (timer_next)
   );

   // Banks are decoded from the register contents after this item.
   ecbm_bank_decode u_bank_decode (
      .reg_mode    (regs_in[REG_MODE]),
      .reg_control (regs_in[REG_CONTROL]),
      .reg_inner   (regs_in[REG_INNER]),
      .bank_first  (bank_first),
      .bank_second (bank_second)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         setting_ff   <= SETTING_RESET;
         regs_ff[REG_MODE]    <= REG0_RESET;
         regs_ff[REG_CONTROL] <= '0;
         regs_ff[REG_UNUSED]  <= '0;
         regs_ff[REG_INNER]   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         setting_ff   <= setting_in;
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= regs_in[i];
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_mode_ff  <= req_ch.mode;
         in_index_ff <= req_ch.reg_index;
         in_value_ff <= req_ch.reg_value;
      end
      if (advance) begin
         out_first_ff  <= bank_first;
         out_second_ff <= bank_second;
         out_irq_ff    <= timer_next.irq;
         out_count_ff  <= timer_next.count;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.prg_bank_first  = out_first_ff;
   assign rsp_ch.prg_bank_second = out_second_ff;
   assign rsp_ch.irq_line        = out_irq_ff;
   assign rsp_ch.count_left      = out_count_ff;

`ifndef SYNTHESIS
   // An item that leaves the input register always lands in the result register.
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register not loaded after advance");

   // The count can never exceed the longest reload.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_count_ff <= COUNT_MAX))
      else $error("count beyond longest reload");

   // A write to register 1 or 3 with the hold bit set stops the timer.
   a_hold_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && timer_ctrl.arm && !timer_ctrl.tick && hold_bit)
      |=> (out_count_ff == '0 && !out_irq_ff))
      else $error("hold write did not clear timer");
`endif

endmodule

// File: rtl/ecbm_bank_decode.sv
// Program bank decode from the mapper registers.
`timescale 1ns / 1ps

module ecbm_bank_decode (
   input  logic [ecbm_pkg::VAL_W-1:0]  reg_mode,
   input  logic [ecbm_pkg::VAL_W-1:0]  reg_control,
   input  logic [ecbm_pkg::VAL_W-1:0]  reg_inner,
   output logic [ecbm_pkg::BANK_W-1:0] bank_first,
   output logic [ecbm_pkg::BANK_W-1:0] bank_second
);
   import ecbm_pkg::*;

   always_comb begin
      if (!reg_control[INNER_BIT]) begin
         // Outer 32K selection.
         bank_first  = {1'b0, reg_control[2:1], 1'b0};
         bank_second = {1'b0, reg_control[2:1], 1'b1};
      end else begin
         case (reg_mode[3:2])
            INNER_FIXED_FIRST: begin
               bank_first  = BANK_INNER_BASE;
               bank_second = {1'b1, reg_inner[2:0]};
            end
            INNER_FIXED_LAST: begin
               bank_first  = {1'b1, reg_inner[2:0]};
               bank_second = BANK_LAST;
            end
            default: begin
               bank_first  = {1'b1, reg_inner[2:1], 1'b0};
               bank_second = {1'b1, reg_inner[2:1], 1'b1};
            end
         endcase
      end
   end

endmodule

// File: rtl/ecbm_timer.sv
// Countdown timer and interrupt flag.
`timescale 1ns / 1ps

module ecbm_timer (
   input  logic                              clock,
   input  logic                              reset,
   input  ecbm_pkg::timer_ctrl_type          ctrl,
   input  logic [ecbm_pkg::SETTING_W-1:0]    setting,
   output ecbm_pkg::timer_state_type         next_state
);
   import ecbm_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               irq_ff, irq_in;

   always_comb begin
      count_in = count_ff;
      irq_in   = irq_ff;
      if (ctrl.step) begin
         if (ctrl.tick) begin
            if (count_ff != '0) begin
               count_in = count_ff - COUNT_W'(1);
               if (count_ff == COUNT_W'(1)) begin
                  irq_in = 1'b1;
               end
            end
         end else if (ctrl.arm) begin
            if (ctrl.hold) begin
               count_in = '0;
               irq_in   = 1'b0;
            end else if (count_ff == '0) begin
               count_in = reload_value(setting);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         irq_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         irq_ff   <= irq_in;
      end
   end

   assign next_state.count = count_in;
   assign next_state.irq   = irq_in;

endmodule
